// ===== rtl/echo_line_editor_macros.svh =====
// Assertion macros for the line editor RTL (included by eled_emit).
`ifndef ECHO_LINE_EDITOR_MACROS_SVH
`define ECHO_LINE_EDITOR_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked on every rising edge outside reset.
`define ELE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked on every rising edge outside reset.
`define ELE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ELE_ASSERT_IMP(label, ante, cons, msg)
`define ELE_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/eled_pkg.sv =====
// Types, constants and helpers for the echo line editor.
package eled_pkg;

  localparam int CHAR_W   = 8;
  localparam int PLAN_N   = 3;
  localparam int IDX_W    = 2;

  localparam logic [CHAR_W-1:0] MAX_LINE    = 8'd255;
  localparam logic [CHAR_W-1:0] LIMIT_RESET = 8'd127;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7F;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

  // Register addresses on the configuration port
  localparam int PADDR_W = 2;
  localparam logic [PADDR_W-1:0] ADDR_LINE_LIMIT = 2'd0;

  typedef struct packed {
    logic [CHAR_W-1:0] char_in;
    logic              at_end;
  } in_t;

  typedef struct packed {
    logic              echo_valid;
    logic [CHAR_W-1:0] echo_char;
    logic              store_valid;
    logic [CHAR_W-1:0] store_index;
    logic [CHAR_W-1:0] store_char;
    logic              line_done;
    logic [CHAR_W-1:0] line_length;
    logic              end_of_input;
    logic              last;
  } out_t;

  // Decoded results of one input item, handed to the emitter
  typedef struct packed {
    logic                 valid;
    logic [IDX_W-1:0]     cnt;
    out_t [PLAN_N-1:0]    res;
  } plan_t;

  // Echo-only result
  function automatic out_t mk_echo(input logic [CHAR_W-1:0] ch, input logic lst);
    out_t r;
    r = '0;
    r.echo_valid = 1'b1;
    r.echo_char  = ch;
    r.last       = lst;
    return r;
  endfunction

  // Terminator write at a line's end or when the line fills
  function automatic out_t mk_term(input logic [CHAR_W-1:0] idx, input logic lst);
    out_t r;
    r = '0;
    r.store_valid = 1'b1;
    r.store_index = idx;
    r.store_char  = CH_NUL;
    r.last        = lst;
    return r;
  endfunction

endpackage

// ===== rtl/eled_front.sv =====
// Input decode: line state, and the result plan for each accepted beat.
module eled_front import eled_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_data,
  input  logic [CHAR_W-1:0] line_limit,
  input  logic              take,
  output plan_t             plan
);

  logic [CHAR_W-1:0] line_position;
  logic [CHAR_W-1:0] line_position_next;
  logic              draining;
  logic              draining_next;
  plan_t             plan_next;

  logic [CHAR_W-1:0] lim;
  logic [CHAR_W-1:0] pos_inc;
  logic              pre_term;
  logic              end_line;
  logic              is_bs;
  logic              is_print;
  logic              accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = !plan.valid || take;

  // Decode the beat against the current line state
  always_comb begin
    lim      = (line_limit < MAX_LINE) ? line_limit : MAX_LINE;
    pos_inc  = line_position + 8'd1;
    pre_term = !draining && (line_position >= lim);
    end_line = in_data.at_end || (in_data.char_in == CH_NL) || (in_data.char_in == CH_CR);
    is_bs    = (in_data.char_in == CH_BS) || (in_data.char_in == CH_DEL);
    is_print = (in_data.char_in >= CH_SPACE) && (in_data.char_in < CH_DEL);

    line_position_next = line_position;
    draining_next      = draining;
    plan_next          = '0;

    if (pre_term) begin
      // Line already full: terminate, then treat the beat as drained input
      plan_next.res[0] = mk_term(line_position, !end_line);
      if (end_line) begin
        plan_next.res[1]             = mk_echo(CH_NL, 1'b1);
        plan_next.res[1].line_done   = 1'b1;
        plan_next.res[1].line_length = line_position;
        plan_next.cnt                = 2'd2;
        line_position_next           = '0;
        draining_next                = 1'b0;
      end else begin
        plan_next.cnt = 2'd1;
        draining_next = 1'b1;
      end
    end else if (draining) begin
      if (end_line) begin
        plan_next.res[0]             = mk_echo(CH_NL, 1'b1);
        plan_next.res[0].line_done   = 1'b1;
        plan_next.res[0].line_length = line_position;
        plan_next.cnt                = 2'd1;
        line_position_next           = '0;
        draining_next                = 1'b0;
      end
    end else if (in_data.at_end) begin
      plan_next.res[0]              = mk_echo(CH_NL, 1'b1);
      plan_next.res[0].end_of_input = 1'b1;
      plan_next.cnt                 = 2'd1;
      line_position_next            = '0;
    end else if (end_line) begin
      // Newline or CR: echo, terminate and report the length
      plan_next.res[0]             = mk_term(line_position, 1'b1);
      plan_next.res[0].echo_valid  = 1'b1;
      plan_next.res[0].echo_char   = CH_NL;
      plan_next.res[0].line_done   = 1'b1;
      plan_next.res[0].line_length = line_position;
      plan_next.cnt                = 2'd1;
      line_position_next           = '0;
    end else if (is_bs) begin
      if (line_position != '0) begin
        plan_next.res[0]   = mk_echo(CH_BS, 1'b0);
        plan_next.res[1]   = mk_echo(CH_SPACE, 1'b0);
        plan_next.res[2]   = mk_echo(CH_BS, 1'b1);
        plan_next.cnt      = 2'd3;
        line_position_next = line_position - 8'd1;
      end
    end else if (is_print) begin
      plan_next.res[0]            = mk_echo(in_data.char_in, 1'b1);
      plan_next.res[0].store_valid = 1'b1;
      plan_next.res[0].store_index = line_position;
      plan_next.res[0].store_char  = in_data.char_in;
      plan_next.cnt                = 2'd1;
      line_position_next           = pos_inc;
      if (pos_inc >= lim) begin
        // Line just filled: add the terminator and start draining
        plan_next.res[0].last = 1'b0;
        plan_next.res[1]      = mk_term(pos_inc, 1'b1);
        plan_next.cnt         = 2'd2;
        draining_next         = 1'b1;
      end
    end
    plan_next.valid = (plan_next.cnt != '0);
  end

  // Advance state and load the plan on each accepted beat; clear it when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      line_position <= '0;
      draining      <= 1'b0;
      plan          <= '0;
    end else if (accept) begin
      line_position <= line_position_next;
      draining      <= draining_next;
      plan          <= plan_next;
    end else if (take) begin
      plan.valid    <= 1'b0;
    end
  end

endmodule

// ===== rtl/eled_emit.sv =====
// Result sequencer: sends the planned results one beat at a time.
`include "echo_line_editor_macros.svh"
module eled_emit import eled_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  plan_t plan,
  output logic  take,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_data
);

  logic [IDX_W-1:0] idx;
  logic             load;
  logic             at_last;

  assign load    = !out_valid || out_ready;
  assign at_last = (idx == (plan.cnt - 2'd1));
  assign take    = plan.valid && load && at_last;

  // Step through the plan while the output register is free
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else if (plan.valid && load) begin
      out_valid <= 1'b1;
      idx       <= at_last ? '0 : idx + 2'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (plan.valid && load) begin
      out_data <= plan.res[idx];
    end
  end

  `ELE_ASSERT_IMP(a_idx_in_plan, plan.valid, idx < plan.cnt, "result index past plan")
  `ELE_ASSERT_IMP(a_plan_nonempty, plan.valid, plan.cnt != 2'd0, "empty plan held")
  `ELE_ASSERT_IMP(a_idx_idle, !plan.valid, idx == '0, "index not rewound")
  `ELE_ASSERT_NXT(a_take_last, take, out_valid && out_data.last, "plan done without last")

endmodule

// ===== rtl/echo_line_editor.sv =====
// Top level of the echo line editor: config register and the two stages.
//
// Line discipline with echo and backspace. Each input beat on in_valid /
// in_ready carries one received byte (char_in) or an end mark (at_end).
// Each output beat on out_valid / out_ready carries one result: an echo
// byte, a line store write, a line-done report or an end-of-input flag;
// the last result of an input beat has last set. An input causes 0 to 3
// results.
// Results pass through the plan register, then the output register. The
// output register takes one result per cycle while the receiver does not
// stall; a beat with no result loads no plan and leaves in_ready high.
// A new beat is accepted while the previous beat's last result still sits
// in the output register. When the receiver stalls, the output register
// holds and the decoded plan holds behind it, so in_ready drops.
// Reset (rst, synchronous) empties the line, leaves draining, clears both
// stages, sets line_limit to 127. The user must write line_limit over the
// APB port at address 0 only while the block is idle; it is not enforced.
module echo_line_editor import eled_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_t                in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_t               out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [CHAR_W-1:0] line_limit;
  plan_t             plan;
  logic              take;

  assign pready = 1'b1;

  // Write the limit register on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && (paddr == ADDR_LINE_LIMIT)) begin
      line_limit <= pwdata[CHAR_W-1:0];
    end
  end

  // Read back the register
  always_comb begin
    prdata = '0;
    if (paddr == ADDR_LINE_LIMIT) begin
      prdata = {{(32-CHAR_W){1'b0}}, line_limit};
    end
  end

  eled_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .line_limit (line_limit),
    .take       (take),
    .plan       (plan)
  );

  eled_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .plan      (plan),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the echo line editor: directed script, random phases, APB limits.
`timescale 1ns / 1ps

module tb_top;
  import eled_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  // One row of the directed script: either a beat or a line_limit write
  typedef struct {
    bit   is_limit;
    in_t  beat;
    bit   typed;
    out_t res;
  } script_row_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_t                in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_t               out_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Predictor state: its own copy of the line position, drain flag and limit
  logic [7:0] kept = '0;
  logic       dropping = 1'b0;
  logic [7:0] limit_copy = LIMIT_RESET;

  out_t        step_results[$];
  out_t        line_events[$];
  script_row_t script[$];

  // Beat-side side band: a typed expectation travels with the beat
  bit   typed_on = 1'b0;
  out_t typed_res = '0;

  int errors = 0;
  int quiet_cycles = 0;
  int beats_taken = 0;
  int active_beats = 0;
  int results_seen = 0;
  int lines_done = 0;
  int line_fills = 0;
  int ends_seen = 0;
  int limit_writes = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_cnt = 0;

  echo_line_editor dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Work out the results of one accepted beat and advance the line state
  function automatic int discipline_step(in_t beat);
    out_t       r;
    logic [7:0] ch;
    ch = beat.char_in;
    step_results.delete();
    // Close the line first when the limit sits at or below the position
    if (!dropping && kept >= limit_copy) begin
      r = '0;
      r.store_valid = 1'b1;
      r.store_index = kept;
      step_results.push_back(r);
      dropping = 1'b1;
    end
    if (dropping) begin
      if (beat.at_end || ch == CH_NL || ch == CH_CR) begin
        r = '0;
        r.echo_valid  = 1'b1;
        r.echo_char   = CH_NL;
        r.line_done   = 1'b1;
        r.line_length = kept;
        step_results.push_back(r);
        kept = '0;
        dropping = 1'b0;
      end
    end else if (beat.at_end) begin
      r = '0;
      r.echo_valid   = 1'b1;
      r.echo_char    = CH_NL;
      r.end_of_input = 1'b1;
      step_results.push_back(r);
      kept = '0;
    end else if (ch == CH_NL || ch == CH_CR) begin
      r = '0;
      r.echo_valid  = 1'b1;
      r.echo_char   = CH_NL;
      r.store_valid = 1'b1;
      r.store_index = kept;
      r.line_done   = 1'b1;
      r.line_length = kept;
      step_results.push_back(r);
      kept = '0;
    end else if (ch == CH_BS || ch == CH_DEL) begin
      // Rub out one character: backspace, space, backspace
      if (kept > 0) begin
        kept = kept - 8'd1;
        r = '0;
        r.echo_valid = 1'b1;
        r.echo_char  = CH_BS;
        step_results.push_back(r);
        r.echo_char  = CH_SPACE;
        step_results.push_back(r);
        r.echo_char  = CH_BS;
        step_results.push_back(r);
      end
    end else if (ch >= CH_SPACE && ch < CH_DEL) begin
      r = '0;
      r.echo_valid  = 1'b1;
      r.echo_char   = ch;
      r.store_valid = 1'b1;
      r.store_index = kept;
      r.store_char  = ch;
      step_results.push_back(r);
      kept = kept + 8'd1;
      // Terminate a full line and start dropping
      if (kept >= limit_copy) begin
        r = '0;
        r.store_valid = 1'b1;
        r.store_index = kept;
        step_results.push_back(r);
        dropping = 1'b1;
      end
    end
    if (step_results.size() > 0) begin
      r = step_results.pop_back();
      r.last = 1'b1;
      step_results.push_back(r);
    end
    return step_results.size();
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Single-result expectation, typed in for the obvious directed rows
  function automatic out_t single_result(logic ev, logic [7:0] ec, logic sv, logic [7:0] si,
                                         logic [7:0] sc, logic ld, logic [7:0] ll, logic eoi);
    out_t r;
    r = '0;
    r.echo_valid   = ev;
    r.echo_char    = ec;
    r.store_valid  = sv;
    r.store_index  = si;
    r.store_char   = sc;
    r.line_done    = ld;
    r.line_length  = ll;
    r.end_of_input = eoi;
    r.last         = 1'b1;
    return r;
  endfunction

  function automatic void add_beat(logic [7:0] ch, logic at_end);
    script_row_t row;
    row.is_limit = 1'b0;
    row.beat.char_in = ch;
    row.beat.at_end = at_end;
    row.typed = 1'b0;
    row.res = '0;
    script.push_back(row);
  endfunction

  function automatic void add_checked(logic [7:0] ch, logic at_end, out_t res);
    script_row_t row;
    row.is_limit = 1'b0;
    row.beat.char_in = ch;
    row.beat.at_end = at_end;
    row.typed = 1'b1;
    row.res = res;
    script.push_back(row);
  endfunction

  function automatic void add_limit(logic [7:0] v);
    script_row_t row;
    row.is_limit = 1'b1;
    row.beat.char_in = v;
    row.beat.at_end = 1'b0;
    row.typed = 1'b0;
    row.res = '0;
    script.push_back(row);
  endfunction

  // Mostly well-formed typing with random content, plus noise
  function automatic in_t random_beat(bit fill_mode);
    in_t b;
    int  pick;
    b.at_end = 1'b0;
    b.char_in = 8'($urandom_range(32, 126));
    pick = $urandom_range(0, 99);
    if (dropping && pick < 30) begin
      // End the dropped line
      case (pick % 3)
        0: b.char_in = CH_NL;
        1: b.char_in = CH_CR;
        default: begin
          b.at_end = 1'b1;
          b.char_in = 8'($urandom);
        end
      endcase
    end else if (fill_mode) begin
      if (pick < 5) b.char_in = pick[0] ? CH_BS : CH_DEL;
      else if (pick < 8) b.char_in = 8'($urandom_range(0, 31));
      else if (pick < 10) b.char_in = 8'($urandom_range(128, 255));
    end else begin
      if (pick < 12) b.char_in = pick[0] ? CH_BS : CH_DEL;
      else if (pick < 22) b.char_in = pick[0] ? CH_NL : CH_CR;
      else if (pick < 26) begin
        b.at_end = 1'b1;
        b.char_in = 8'($urandom);
      end
      else if (pick < 32) b.char_in = 8'($urandom_range(0, 31));
      else if (pick < 38) b.char_in = 8'($urandom_range(128, 255));
    end
    return b;
  endfunction

  // Send one beat in bursts with random gaps; returns at the falling edge after acceptance
  task automatic send_beat(in_t beat, bit typed, out_t res);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
    end
    in_valid  <= 1'b1;
    in_data   <= beat;
    typed_on  <= typed;
    typed_res <= res;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    burst_left--;
  endtask

  // Hold off input until every awaited result is out and the block is quiet
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (line_events.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write line_limit over APB, then read it back
  task automatic write_limit(logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_LINE_LIMIT;
    pwdata  <= {24'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    limit_copy = v;
    limit_writes++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("prdata", v, prdata[7:0]);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Receiver: stall on a pattern whose mode changes when a random countdown runs out
  always @(negedge clk) begin
    if (stall_cnt == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_cnt = $urandom_range(20, 80);
    end
    stall_cnt--;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= (stall_cnt % 4 != 0);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Predict on accepted beats, check accepted results, watch for a hang
  always @(posedge clk) begin
    out_t want;
    int   n;
    if (!rst) begin
      if (in_valid && in_ready) begin
        n = discipline_step(in_data);
        beats_taken++;
        if (n > 0) active_beats++;
        if (typed_on) line_events.push_back(typed_res);
        else foreach (step_results[i]) line_events.push_back(step_results[i]);
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_data.line_done) lines_done++;
        if (out_data.store_valid && !out_data.echo_valid) line_fills++;
        if (out_data.end_of_input) ends_seen++;
        if (line_events.size() == 0) begin
          $display("%0t: result with nothing awaited, actual %h", $time, out_data);
          errors++;
        end else begin
          want = line_events.pop_front();
          check_field("echo_valid", want.echo_valid, out_data.echo_valid);
          check_field("echo_char", want.echo_char, out_data.echo_char);
          check_field("store_valid", want.store_valid, out_data.store_valid);
          check_field("store_index", want.store_index, out_data.store_index);
          check_field("store_char", want.store_char, out_data.store_char);
          check_field("line_done", want.line_done, out_data.line_done);
          check_field("line_length", want.line_length, out_data.line_length);
          check_field("end_of_input", want.end_of_input, out_data.end_of_input);
          check_field("last", want.last, out_data.last);
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results still awaited",
                 $time, QUIET_LIMIT, line_events.size());
        $display("echo_line_editor test failed");
        $finish;
      end
    end
  end

  // Stimulus: directed script, then random phases over several limits
  initial begin
    in_t        b;
    int         base;
    int         quota;
    logic [7:0] lim;

    // Directed script, limit at its reset value of 127
    add_checked(8'h41, 1'b0, single_result(1, 8'h41, 1, 8'd0, 8'h41, 0, 8'd0, 0));
    add_beat(CH_SPACE, 1'b0);
    add_beat(8'h7E, 1'b0);
    add_beat(CH_BS, 1'b0);
    add_beat(CH_DEL, 1'b0);
    add_beat(8'h1F, 1'b0);
    add_beat(8'h80, 1'b0);
    add_beat(8'hFF, 1'b0);
    add_beat(CH_NUL, 1'b0);
    add_beat(CH_CR, 1'b0);
    // Backspace on an empty line, end on an empty line, empty line
    add_beat(CH_BS, 1'b0);
    add_checked(8'hFF, 1'b1, single_result(1, CH_NL, 0, 8'd0, 8'd0, 0, 8'd0, 1));
    add_checked(CH_NL, 1'b0, single_result(1, CH_NL, 1, 8'd0, 8'd0, 1, 8'd0, 0));
    // Line fills at once, drop until newline, then until end of input
    add_limit(8'd1);
    add_beat(8'h7A, 1'b0);
    add_beat(8'h71, 1'b0);
    add_beat(CH_BS, 1'b0);
    add_beat(CH_NL, 1'b0);
    add_beat(8'h61, 1'b0);
    add_beat(8'h00, 1'b1);
    // Limit lowered below the position mid-line
    add_limit(8'd127);
    add_beat(8'h61, 1'b0);
    add_beat(8'h62, 1'b0);
    add_beat(8'h63, 1'b0);
    add_limit(8'd2);
    add_beat(8'h64, 1'b0);
    add_beat(CH_CR, 1'b0);
    add_limit(8'd255);
    add_beat(8'h55, 1'b1);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (script[i]) begin
      if (script[i].is_limit) begin
        settle();
        write_limit(script[i].beat.char_in);
      end else begin
        send_beat(script[i].beat, script[i].typed, script[i].res);
      end
    end

    // Random phases: one long line up to the widest limit, short limits, then 127
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: lim = 8'd255;
        1: lim = 8'd1;
        2: lim = 8'd2;
        5: lim = 8'd127;
        default: lim = 8'($urandom_range(3, 12));
      endcase
      quota = (p == 0) ? 290 : 6;
      settle();
      write_limit(lim);
      base = active_beats;
      while (active_beats - base < quota) begin
        b = random_beat(p == 0);
        send_beat(b, 1'b0, '0);
      end
    end

    // Drain and let the block go quiet
    in_valid <= 1'b0;
    while (line_events.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Ran %0d beats (%0d with results) under %0d limit writes, %0d results checked.",
             beats_taken, active_beats, limit_writes, results_seen);
    $display("Saw %0d finished lines, %0d line fills, %0d end-of-input reports.",
             lines_done, line_fills, ends_seen);
    if (line_events.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, line_events.size());
      errors++;
    end
    if (errors == 0) begin
      $display("echo_line_editor test passed");
    end else begin
      $display("echo_line_editor test failed");
    end
    $finish;
  end

endmodule
